// ===== rtl/c3ac_pkg.sv =====
// c3ac_pkg: shared types and constants of the 3x3 abs/clip convolution core.
// No dependencies; imported by c3ac_cell, c3ac_lane, the core and the bench.
package c3ac_pkg;

  localparam int KDIM       = 3;
  localparam int PIX_W      = 8;
  localparam int COEF_W     = 8;
  localparam int KROW_W     = KDIM * COEF_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int IMG_W_W    = 11;
  localparam int IMG_H_W    = 16;
  localparam int IN_ROW_W   = IMG_H_W + 1;
  localparam int PROD_W     = PIX_W + 1 + COEF_W;
  localparam int CSUM_W     = PROD_W + 2;
  localparam int TSUM_W     = CSUM_W + 2;
  localparam int PIX_MAX    = 255;
  localparam int OQ_DEPTH   = 8;
  localparam int OQ_AW      = $clog2(OQ_DEPTH);

  localparam logic [IMG_W_W-1:0] WIDTH_RST  = IMG_W_W'(1024);
  localparam logic [IMG_H_W-1:0] HEIGHT_RST = IMG_H_W'(1024);

  localparam logic REQ_DRAIN = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KTOP   = 3'd0,
    REG_KMID   = 3'd1,
    REG_KBOT   = 3'd2,
    REG_WIDTH  = 3'd3,
    REG_HEIGHT = 3'd4
  } cfg_reg_e;

  typedef logic [PIX_W-1:0] pix_t;
  typedef pix_t [KDIM-1:0] pix_col_t;       // [0] top row, [2] bottom row
  typedef logic signed [COEF_W-1:0] coef_t;
  typedef coef_t [KDIM-1:0] coef_col_t;     // indexed by kernel row
  typedef logic signed [CSUM_W-1:0] csum_t;

  typedef struct packed {
    logic top;   // top row replaced by center row
    logic bot;   // bottom row replaced by center row
  } row_clamp_t;

  typedef struct packed {
    row_clamp_t row;
    logic       left;
    logic       right;
    logic       last;
  } pos_t;

  typedef struct packed {
    logic       req_type;
    logic [7:0] pixel_in;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] pixel_out;
    logic       frame_last;
  } out_beat_t;

endpackage

// ===== rtl/c3ac_stream_if.sv =====
// c3ac_stream_if: valid/ready stream channel carrying one payload beat.
// Payload type is a parameter; no package dependency.
interface c3ac_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/c3ac_ram.sv =====
// c3ac_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module c3ac_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

// ===== rtl/c3ac_cell.sv =====
// c3ac_cell: one window column (three pixels) of the 3x3 shift window.
// Uses c3ac_pkg; chained cell to cell by the top level.
module c3ac_cell
  import c3ac_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       shift_i,
  input  pix_col_t   col_i,
  input  row_clamp_t clamp_i,
  output pix_col_t   col_o,
  output pix_col_t   sel_o
);
  pix_col_t col_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
    end else if (shift_i) begin
      col_q <= col_i;
    end
  end

  // clamp-to-edge on rows: missing neighbor row takes the center row
  always_comb begin
    sel_o    = col_q;
    sel_o[0] = clamp_i.top ? col_q[1] : col_q[0];
    sel_o[2] = clamp_i.bot ? col_q[1] : col_q[2];
  end

  assign col_o = col_q;
endmodule

// ===== rtl/c3ac_lane.sv =====
// c3ac_lane: one kernel column: three products, then their registered sum.
// Uses c3ac_pkg; the products are registered, then the sum.
module c3ac_lane
  import c3ac_pkg::*;
(
  input  logic      clk_i,
  input  pix_col_t  pix_i,
  input  coef_col_t coef_i,
  output csum_t     sum_o
);
  logic signed [PROD_W-1:0] prod_d [KDIM];
  logic signed [PROD_W-1:0] prod_q [KDIM];
  csum_t                    sum_d;
  csum_t                    sum_q;

  always_comb begin
    for (int r = 0; r < KDIM; r++) begin
      prod_d[r] = $signed({1'b0, pix_i[r]}) * $signed(coef_i[r]);
    end
  end

  always_comb begin
    sum_d = '0;
    for (int r = 0; r < KDIM; r++) begin
      sum_d = sum_d + CSUM_W'(prod_q[r]);
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    sum_q  <= sum_d;
  end

  assign sum_o = sum_q;
endmodule

// ===== rtl/conv3x3_abs_clip_core.sv =====
// conv3x3_abs_clip_core: streaming 3x3 correlation, |sum| clipped to 255, clamped borders.
// A beat passes stage 1, the window cells, lane products and sums, then the output queue.
// Throughput: one beat per cycle while queue credit allows, set by the line store writes.
// Reset: counters, window and kernels clear, width/height go to 1024; line stores
// are not cleared, their stale entries only reach border-clamped positions.
module conv3x3_abs_clip_core
  import c3ac_pkg::*;
#(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  c3ac_stream_if.sink           in_i,
  c3ac_stream_if.source         out_o
);
  localparam int AW = $clog2(MAX_WIDTH);      // line store address
  localparam int WW = $clog2(MAX_WIDTH + 1);  // column counts up to MAX_WIDTH

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [KROW_W-1:0]  kern_q [KDIM];
  logic [IMG_W_W-1:0] width_q;
  logic [IMG_H_W-1:0] height_q;
  logic               geo_wr;

  assign geo_wr = cfg_we_i &&
                  (cfg_idx_i == REG_WIDTH || cfg_idx_i == REG_HEIGHT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < KDIM; r++) begin
        kern_q[r] <= '0;
      end
      width_q  <= WIDTH_RST;
      height_q <= HEIGHT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_KTOP:   kern_q[0] <= cfg_data_i[KROW_W-1:0];
        REG_KMID:   kern_q[1] <= cfg_data_i[KROW_W-1:0];
        REG_KBOT:   kern_q[2] <= cfg_data_i[KROW_W-1:0];
        REG_WIDTH:  width_q   <= cfg_data_i[IMG_W_W-1:0];
        REG_HEIGHT: height_q  <= cfg_data_i[IMG_H_W-1:0];
        default: ;
      endcase
    end
  end

  // effective geometry: width 0 -> 1, above MAX_WIDTH -> MAX_WIDTH; height 0 -> 1
  logic [WW-1:0]      w_eff;
  logic [IMG_H_W-1:0] h_eff;

  always_comb begin
    if (width_q == '0) begin
      w_eff = WW'(1);
    end else if (32'(width_q) > 32'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(width_q);
    end
    h_eff = (height_q == '0) ? IMG_H_W'(1) : height_q;
  end

  // ---------------------------------------------------------------------------
  // Accept stage: all position bookkeeping happens on the accepting beat, so
  // the next beat always sees up-to-date counters (incl. end-of-frame clear).
  // ---------------------------------------------------------------------------
  logic [WW-1:0]       in_col_q, out_col_q;
  logic [IN_ROW_W-1:0] in_row_q;
  logic [IMG_H_W-1:0]  out_row_q;

  logic          accept, is_drain, done, take, emit;
  logic [WW-1:0] col_inc, ocol_inc;
  logic          row_end, ocol_end, orow_end;
  pos_t          pos;

  assign accept   = in_i.valid & in_i.ready;
  assign is_drain = in_i.data.req_type == REQ_DRAIN;
  assign done     = in_row_q >= {1'b0, h_eff};
  // pixels after the last row and drains before it are dropped
  assign take     = accept && (is_drain == done);
  assign emit     = (in_row_q >= IN_ROW_W'(2)) ||
                    (in_row_q == IN_ROW_W'(1) && in_col_q != '0);

  assign col_inc  = in_col_q + WW'(1);
  assign row_end  = col_inc >= w_eff;
  assign ocol_inc = out_col_q + WW'(1);
  assign ocol_end = ocol_inc >= w_eff;
  assign orow_end = ({1'b0, out_row_q} + IN_ROW_W'(1)) >= {1'b0, h_eff};

  always_comb begin
    pos.row.top = out_row_q == '0;
    pos.row.bot = orow_end;
    pos.left    = out_col_q == '0;
    pos.right   = ocol_end;
    pos.last    = orow_end & ocol_end;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
    end else if (geo_wr || (take && emit && pos.last)) begin
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
    end else if (take) begin
      in_col_q <= row_end ? '0 : col_inc;
      in_row_q <= in_row_q + IN_ROW_W'(row_end);
      if (emit) begin
        out_col_q <= ocol_end ? '0 : ocol_inc;
        out_row_q <= out_row_q + IMG_H_W'(ocol_end);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: line store read data arrives; rotate line stores and feed window
  // ---------------------------------------------------------------------------
  logic          s1_vld_q, s1_emit_q, fwd_q;
  logic [AW-1:0] s1_col_q;
  pix_t          s1_pix_q, fwd_above_q, fwd_mid_q;
  pos_t          s1_pos_q;
  pix_t          upper_rd, lower_rd, s1_above, s1_mid;
  logic [AW-1:0] rd_addr;

  assign rd_addr = in_col_q[AW-1:0];

  // one-column images read the entry that the beat ahead writes this cycle
  assign s1_above = fwd_q ? fwd_above_q : upper_rd;
  assign s1_mid   = fwd_q ? fwd_mid_q : lower_rd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      fwd_q    <= 1'b0;
    end else begin
      s1_vld_q <= take;
      if (take) begin
        fwd_q <= s1_vld_q && (s1_col_q == rd_addr);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      s1_col_q    <= rd_addr;
      s1_pix_q    <= is_drain ? '0 : in_i.data.pixel_in;
      s1_emit_q   <= emit;
      s1_pos_q    <= pos;
      fwd_above_q <= s1_mid;
      fwd_mid_q   <= s1_pix_q;
    end
  end

  c3ac_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_line_upper (
    .clk_i   (clk_i),
    .we_i    (s1_vld_q),
    .waddr_i (s1_col_q),
    .wdata_i (s1_mid),
    .re_i    (take),
    .raddr_i (rd_addr),
    .rdata_o (upper_rd)
  );

  c3ac_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_line_lower (
    .clk_i   (clk_i),
    .we_i    (s1_vld_q),
    .waddr_i (s1_col_q),
    .wdata_i (s1_pix_q),
    .re_i    (take),
    .raddr_i (rd_addr),
    .rdata_o (lower_rd)
  );

  // ---------------------------------------------------------------------------
  // Stage 2: window cells. Newest column enters the rightmost cell and moves
  // one cell left per beat. Only emitting beats continue down the pipe.
  // ---------------------------------------------------------------------------
  logic     s2_vld_q;
  pos_t     s2_pos_q;
  pix_col_t new_col;
  pix_col_t cell_col [KDIM];
  pix_col_t cell_sel [KDIM];

  always_comb begin
    new_col[0] = s1_above;
    new_col[1] = s1_mid;
    new_col[2] = s1_pix_q;
  end

  for (genvar j = 0; j < KDIM; j++) begin : g_cell
    if (j == KDIM - 1) begin : g_head
      c3ac_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .shift_i (s1_vld_q),
        .col_i   (new_col),
        .clamp_i (s2_pos_q.row),
        .col_o   (cell_col[j]),
        .sel_o   (cell_sel[j])
      );
    end else begin : g_body
      c3ac_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .shift_i (s1_vld_q),
        .col_i   (cell_col[j+1]),
        .clamp_i (s2_pos_q.row),
        .col_o   (cell_col[j]),
        .sel_o   (cell_sel[j])
      );
    end
  end

  // ---------------------------------------------------------------------------
  // Stages 3-4: per-column multiply lanes; column clamp picks the center cell
  // ---------------------------------------------------------------------------
  pix_col_t  lane_pix  [KDIM];
  coef_col_t lane_coef [KDIM];
  csum_t     lane_sum  [KDIM];

  always_comb begin
    lane_pix[0] = s2_pos_q.left ? cell_sel[1] : cell_sel[0];
    lane_pix[1] = cell_sel[1];
    lane_pix[2] = s2_pos_q.right ? cell_sel[1] : cell_sel[2];
    // left coefficient sits in the top byte of each kernel row
    for (int c = 0; c < KDIM; c++) begin
      for (int r = 0; r < KDIM; r++) begin
        lane_coef[c][r] = kern_q[r][COEF_W*(KDIM-1-c) +: COEF_W];
      end
    end
  end

  for (genvar c = 0; c < KDIM; c++) begin : g_lane
    c3ac_lane u_lane (
      .clk_i  (clk_i),
      .pix_i  (lane_pix[c]),
      .coef_i (lane_coef[c]),
      .sum_o  (lane_sum[c])
    );
  end

  logic s3_vld_q, s4_vld_q, s3_last_q, s4_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
      s4_vld_q <= 1'b0;
    end else begin
      s2_vld_q <= s1_vld_q & s1_emit_q;
      s3_vld_q <= s2_vld_q;
      s4_vld_q <= s3_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_pos_q  <= s1_pos_q;
    s3_last_q <= s2_pos_q.last;
    s4_last_q <= s3_last_q;
  end

  // final sum, magnitude and saturation
  logic signed [TSUM_W-1:0] tot;
  logic [TSUM_W-1:0]        mag;
  out_beat_t                push_beat;

  always_comb begin
    tot = '0;
    for (int c = 0; c < KDIM; c++) begin
      tot = tot + TSUM_W'(lane_sum[c]);
    end
    mag = tot[TSUM_W-1] ? TSUM_W'(-tot) : TSUM_W'(tot);
    push_beat.pixel_out  = (mag > TSUM_W'(PIX_MAX)) ? 8'(PIX_MAX) : mag[7:0];
    push_beat.frame_last = s4_last_q;
  end

  // ---------------------------------------------------------------------------
  // Output queue. Input is taken only while the queue can absorb every beat
  // still in the pipe, so the datapath never stalls on the output side.
  // ---------------------------------------------------------------------------
  out_beat_t        oq_mem_q [OQ_DEPTH];
  logic [OQ_AW-1:0] oq_wr_q, oq_rd_q;
  logic [OQ_AW:0]   oq_cnt_q;
  logic [2:0]       inflight;
  logic [OQ_AW+1:0] credit;
  logic             push, pop;

  assign push     = s4_vld_q;
  assign pop      = out_o.valid & out_o.ready;
  assign inflight = 3'(s1_vld_q) + 3'(s2_vld_q) + 3'(s3_vld_q) + 3'(s4_vld_q);
  assign credit   = {1'b0, oq_cnt_q} + (OQ_AW+2)'(inflight);

  assign in_i.ready  = credit < (OQ_AW+2)'(OQ_DEPTH);
  assign out_o.valid = oq_cnt_q != '0;
  assign out_o.data  = oq_mem_q[oq_rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oq_wr_q  <= '0;
      oq_rd_q  <= '0;
      oq_cnt_q <= '0;
    end else begin
      if (push) begin
        oq_wr_q <= oq_wr_q + OQ_AW'(1);
      end
      if (pop) begin
        oq_rd_q <= oq_rd_q + OQ_AW'(1);
      end
      oq_cnt_q <= oq_cnt_q + (OQ_AW+1)'(push) - (OQ_AW+1)'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      oq_mem_q[oq_wr_q] <= push_beat;
    end
  end

endmodule

// ===== sim/tb_conv3x3_abs_clip_core.sv =====
// tb_conv3x3_abs_clip_core: self-checking bench for the 3x3 abs/clip convolution core.
// Streams raster frames with random gaps and stalls, predicts every output pixel and
// checks it; needs c3ac_pkg, c3ac_stream_if and conv3x3_abs_clip_core.
module tb_conv3x3_abs_clip_core;
  import c3ac_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_W        = 1024;
  localparam int RANDOM_BEATS = 560;
  localparam int SETTLE_LIMIT = 5000;   // cycles allowed for outstanding pixels
  localparam int PIPE_SETTLE  = 12;     // time for the core's pipeline to empty
  localparam int MAX_REPORTS  = 40;
  localparam longint TIMEOUT_NS = 64'd5_000_000;

  localparam logic REQ_PIXEL = ~REQ_DRAIN;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 3'd7;

  // Predicts the output stream of the core and holds the pixels still owed.
  class clip_conv_tracker;
    logic [KROW_W-1:0]  krow [KDIM];
    logic [IMG_W_W-1:0] width_reg;
    logic [IMG_H_W-1:0] height_reg;
    pix_t               upper_line [MAX_W];
    pix_t               lower_line [MAX_W];
    pix_t               win [KDIM][KDIM];   // [row][col], col 0 oldest
    int unsigned        in_col, in_row, out_col, out_row;
    out_beat_t          pending_pixels [$];
    int                 fault_count;

    function new();
      foreach (krow[i]) krow[i] = '0;
      width_reg  = WIDTH_RST;
      height_reg = HEIGHT_RST;
      foreach (upper_line[i]) upper_line[i] = '0;
      foreach (lower_line[i]) lower_line[i] = '0;
      foreach (win[r, c]) win[r][c] = '0;
      restart_frame();
      fault_count = 0;
    endfunction

    function void restart_frame();
      in_col  = 0;
      in_row  = 0;
      out_col = 0;
      out_row = 0;
    endfunction

    function int unsigned eff_w();
      if (width_reg == '0) return 1;
      if (width_reg > MAX_W) return MAX_W;
      return width_reg;
    endfunction

    function int unsigned eff_h();
      return (height_reg == '0) ? 1 : height_reg;
    endfunction

    function int pending();
      return pending_pixels.size();
    endfunction

    function void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_KTOP:   krow[0] = val[KROW_W-1:0];
        REG_KMID:   krow[1] = val[KROW_W-1:0];
        REG_KBOT:   krow[2] = val[KROW_W-1:0];
        REG_WIDTH: begin
          width_reg = val[IMG_W_W-1:0];
          restart_frame();
        end
        REG_HEIGHT: begin
          height_reg = val[IMG_H_W-1:0];
          restart_frame();
        end
        default: ;
      endcase
    endfunction

    // Returns 1 when the beat advanced the core, 0 when the core drops it.
    function bit note_beat(in_beat_t b);
      int unsigned w, h, col;
      int unsigned sel_r [KDIM];
      int unsigned sel_c [KDIM];
      bit          drain, emit, last;
      pix_t        pix, above, middle;
      coef_t       k;
      int          acc;
      out_beat_t   res;
      w     = eff_w();
      h     = eff_h();
      drain = (b.req_type == REQ_DRAIN);
      // pixels past the last row and drains inside the frame are dropped
      if (drain != (in_row >= h)) return 1'b0;
      pix = drain ? pix_t'(0) : b.pixel_in;

      col    = in_col % MAX_W;
      above  = upper_line[col];
      middle = lower_line[col];
      upper_line[col] = middle;
      lower_line[col] = pix;
      for (int r = 0; r < KDIM; r++) begin
        win[r][0] = win[r][1];
        win[r][1] = win[r][2];
      end
      win[0][2] = above;
      win[1][2] = middle;
      win[2][2] = pix;

      emit = (in_row >= 2) || (in_row == 1 && in_col >= 1);
      in_col++;
      if (in_col >= w) begin
        in_col = 0;
        in_row++;
      end
      if (!emit) return 1'b1;

      // clamp to edge: out-of-image taps fall back on the center row/column
      sel_r[0] = (out_row == 0) ? 1 : 0;
      sel_r[1] = 1;
      sel_r[2] = (out_row + 1 >= h) ? 1 : 2;
      sel_c[0] = (out_col == 0) ? 1 : 0;
      sel_c[1] = 1;
      sel_c[2] = (out_col + 1 >= w) ? 1 : 2;

      acc = 0;
      for (int r = 0; r < KDIM; r++) begin
        for (int c = 0; c < KDIM; c++) begin
          k = krow[r][KROW_W-1-COEF_W*c -: COEF_W];
          acc += int'(win[sel_r[r]][sel_c[c]]) * int'(k);
        end
      end
      if (acc < 0) acc = -acc;
      if (acc > PIX_MAX) acc = PIX_MAX;

      last = (out_row + 1 >= h) && (out_col + 1 >= w);
      res.pixel_out  = acc[PIX_W-1:0];
      res.frame_last = last;
      pending_pixels.push_back(res);

      if (last) begin
        restart_frame();
      end else begin
        out_col++;
        if (out_col >= w) begin
          out_col = 0;
          out_row++;
        end
      end
      return 1'b1;
    endfunction

    task report_mismatch(string msg);
      fault_count++;
      if (fault_count <= MAX_REPORTS) $display("[%0t] ERROR: %s", $time, msg);
    endtask

    task check_pixel(out_beat_t got);
      out_beat_t want;
      if (pending_pixels.size() == 0) begin
        report_mismatch($sformatf("unexpected pixel %0d last %0b", got.pixel_out,
                                  got.frame_last));
        return;
      end
      want = pending_pixels.pop_front();
      if (got.pixel_out !== want.pixel_out)
        report_mismatch($sformatf("pixel_out %0d, predicted %0d", got.pixel_out,
                                  want.pixel_out));
      if (got.frame_last !== want.frame_last)
        report_mismatch($sformatf("frame_last %0b, predicted %0b", got.frame_last,
                                  want.frame_last));
    endtask
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  c3ac_stream_if #(.T(in_beat_t))  in_ch ();
  c3ac_stream_if #(.T(out_beat_t)) out_ch ();

  clip_conv_tracker tracker = new();
  int idle_pct;         // share of beats preceded by a gap or stall
  int consumed_beats;   // beats that moved the core forward

  conv3x3_abs_clip_core #(
    .MAX_WIDTH(MAX_W)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    if ($urandom_range(0, 99) >= idle_pct) return 0;
    if ($urandom_range(0, 15) == 0) return $urandom_range(8, 40);
    return $urandom_range(1, 3);
  endfunction

  function automatic pix_t rand_pixel();
    case ($urandom_range(0, 9))
      0:       return pix_t'(0);
      1:       return pix_t'(PIX_MAX);
      default: return pix_t'($urandom_range(0, PIX_MAX));
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_kernel();
    case ($urandom_range(0, 11))
      0:       return 24'h000000;
      1:       return 24'h808080;   // all -128
      2:       return 24'h7F7F7F;   // all +127
      3:       return 24'hFFFFFF;   // all -1
      default: return CFG_DATA_W'($urandom_range(0, 24'hFFFFFF));
    endcase
  endfunction

  function automatic logic [IMG_W_W-1:0] pick_width();
    case ($urandom_range(0, 9))
      0:       return '0;                  // behaves as one column
      1:       return IMG_W_W'(1);
      2:       return IMG_W_W'($urandom_range(9, 33));
      default: return IMG_W_W'($urandom_range(2, 8));
    endcase
  endfunction

  function automatic logic [IMG_H_W-1:0] pick_height();
    case ($urandom_range(0, 9))
      0:       return '0;                  // behaves as one row
      1:       return IMG_H_W'(1);
      default: return IMG_H_W'($urandom_range(2, 6));
    endcase
  endfunction

  // One register write per rising edge; the caller drops the enable afterwards.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    tracker.apply_reg(idx, val);
  endtask

  // Full register set; geometry last so the frame restarts on the new settings.
  task automatic program_block(input logic [CFG_DATA_W-1:0] kt, input logic [CFG_DATA_W-1:0] km,
                               input logic [CFG_DATA_W-1:0] kb, input logic [IMG_W_W-1:0] w,
                               input logic [IMG_H_W-1:0] h, input bit poke_unused);
    write_reg(REG_KTOP, kt);
    write_reg(REG_KMID, km);
    write_reg(REG_KBOT, kb);
    write_reg(REG_WIDTH, CFG_DATA_W'(w));
    write_reg(REG_HEIGHT, CFG_DATA_W'(h));
    if (poke_unused)
      write_reg(CFG_IDX_W'($urandom_range(REG_UNUSED_LO, REG_UNUSED_HI)),
                CFG_DATA_W'($urandom_range(0, 24'hFFFFFF)));
    cfg_we_i <= 1'b0;
  endtask

  // Offers one beat after an optional gap; valid stays up across back-to-back beats.
  task automatic send_beat(input logic req, input pix_t pix);
    int       gap;
    in_beat_t b;
    gap        = pick_gap();
    b.req_type = req;
    b.pixel_in = pix;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= b;
    do @(posedge clk_i); while (in_ch.ready !== 1'b1);
    if (tracker.note_beat(b)) consumed_beats++;
  endtask

  // One raster frame plus its width+1 drain beats. With noise, dropped beats
  // (early drains, pixels during the flush, drains after frame end) are mixed in.
  // A short frame stops partway and leaves the rest to a geometry rewrite.
  task automatic stream_frame(input bit noisy, input bit partial);
    int unsigned fw, fh, total, cut;
    fw    = tracker.eff_w();
    fh    = tracker.eff_h();
    total = fw * fh;
    cut   = partial ? $urandom_range(0, total - 1) : total;
    for (int unsigned i = 0; i < cut; i++) begin
      if (noisy && $urandom_range(0, 15) == 0) send_beat(REQ_DRAIN, rand_pixel());
      send_beat(REQ_PIXEL, rand_pixel());
    end
    if (cut < total) return;
    for (int unsigned i = 0; i < fw + 1; i++) begin
      if (noisy && $urandom_range(0, 7) == 0) send_beat(REQ_PIXEL, rand_pixel());
      send_beat(REQ_DRAIN, rand_pixel());
    end
    if (noisy && $urandom_range(0, 3) == 0) send_beat(REQ_DRAIN, rand_pixel());
  endtask

  // Input goes quiet, owed pixels come out, then the pipeline gets time to empty.
  task automatic settle_block();
    int waited;
    in_ch.valid <= 1'b0;
    waited = 0;
    @(posedge clk_i);
    while (tracker.pending() != 0 && waited < SETTLE_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (PIPE_SETTLE) @(posedge clk_i);
  endtask

  task automatic random_phase();
    bit cut_short;
    int frames;
    case ($urandom_range(0, 2))
      0:       idle_pct = 0;
      1:       idle_pct = 20;
      default: idle_pct = 50;
    endcase
    program_block(pick_kernel(), pick_kernel(), pick_kernel(), pick_width(), pick_height(),
                  $urandom_range(0, 3) == 0);
    frames = $urandom_range(1, 3);
    for (int f = 0; f < frames; f++) begin
      cut_short = ($urandom_range(0, 7) == 0);
      stream_frame(1'b1, cut_short);
      if (cut_short) break;
    end
    settle_block();
  endtask

  // Sink side: random stalls on ready, every beat goes to the tracker.
  initial begin
    int gap;
    out_ch.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      gap = pick_gap();
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (out_ch.valid !== 1'b1);
      tracker.check_pixel(out_ch.data);
    end
  end

  initial begin
    pix_t dir_pix [9];
    dir_pix = '{8'd255, 8'd0, 8'd255, 8'd0, 8'd128, 8'd127, 8'd1, 8'd254, 8'd255};
    idle_pct       = 20;
    consumed_beats = 0;
    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= '0;
    cfg_data_i  <= '0;
    in_ch.valid <= 1'b0;
    in_ch.data  <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // drain before any pixel is dropped
    send_beat(REQ_DRAIN, 8'd0);
    settle_block();

    // 3x3 frame with mixed extreme coefficients and pixels, a pixel during the
    // flush and a drain after frame end, both dropped
    program_block(24'h807F01, 24'hFF0280, 24'h7F8000, IMG_W_W'(3), IMG_H_W'(3), 1'b1);
    foreach (dir_pix[i]) send_beat(REQ_PIXEL, dir_pix[i]);
    send_beat(REQ_PIXEL, 8'd200);
    repeat (4) send_beat(REQ_DRAIN, 8'd0);
    send_beat(REQ_DRAIN, 8'd0);
    settle_block();

    // zero geometry acts as 1x1; all -128 taps saturate
    program_block(24'h808080, 24'h808080, 24'h808080, '0, '0, 1'b0);
    send_beat(REQ_PIXEL, 8'd255);
    repeat (2) send_beat(REQ_DRAIN, 8'd0);
    settle_block();

    // zero kernel, single row
    program_block('0, '0, '0, IMG_W_W'(2), IMG_H_W'(1), 1'b1);
    send_beat(REQ_PIXEL, 8'd7);
    send_beat(REQ_PIXEL, 8'd200);
    repeat (3) send_beat(REQ_DRAIN, 8'd0);
    settle_block();

    consumed_beats = 0;
    while (consumed_beats < RANDOM_BEATS) random_phase();

    // geometry extremes, cut short: width above the maximum, tallest image
    idle_pct = 20;
    program_block(pick_kernel(), pick_kernel(), pick_kernel(), '1, IMG_H_W'(1), 1'b0);
    repeat (8) send_beat(REQ_PIXEL, rand_pixel());
    settle_block();
    idle_pct = 0;
    program_block(pick_kernel(), pick_kernel(), pick_kernel(), IMG_W_W'(1), '1, 1'b0);
    repeat (24) send_beat(REQ_PIXEL, rand_pixel());
    settle_block();

    if (tracker.pending() != 0)
      tracker.report_mismatch($sformatf("%0d predicted pixels never came out",
                                        tracker.pending()));
    if (tracker.fault_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("[%0t] ERROR: timeout", $time);
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/c3ac_pkg.sv
rtl/c3ac_stream_if.sv
rtl/c3ac_ram.sv
rtl/c3ac_cell.sv
rtl/c3ac_lane.sv
rtl/conv3x3_abs_clip_core.sv
sim/tb_conv3x3_abs_clip_core.sv
